FILE: sv/irpw_pkg.sv
// irpw_pkg: shared types and constants for the IR pulse-width capture block.
// No dependencies; imported by irpw_cfg and ir_pulse_width_capture_top.
`timescale 1ns / 1ps

package irpw_pkg;

    localparam int MAX_PULSES = 256;
    localparam int ADDR_W     = $clog2(MAX_PULSES);
    localparam int FILL_W     = ADDR_W + 1;
    localparam int DUR_W      = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [DUR_W-1:0] EMPTY_ENTRY = 16'hFFFF;

    // Input operation codes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Result kinds
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TICKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_PERIODS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_GAP_TICKS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSES    = 2'd3;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TIMEOUT = 2'd1,
        ST_ERROR   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        MODE_OFF     = 2'd0,
        MODE_WAIT    = 2'd1,
        MODE_CAPTURE = 2'd2
    } mode_t;

    typedef struct packed {
        logic [1:0] op;
        logic       receiver_level;
        logic [3:0] channel;
        logic [7:0] read_index;
    } irpw_in_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic [7:0]  pulse_count;
        logic [15:0] read_value;
    } irpw_out_t;

    typedef struct packed {
        logic [15:0] period_ticks;
        logic [7:0]  idle_periods;
        logic [15:0] end_gap_ticks;
        logic [7:0]  min_pulses;
    } irpw_cfg_t;

endpackage

FILE: sv/irpw_ram.sv
// irpw_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
`timescale 1ns / 1ps

module irpw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: sv/irpw_cfg.sv
// irpw_cfg: configuration register file for the IR pulse-width capture block.
// Depends on irpw_pkg.
`timescale 1ns / 1ps

module irpw_cfg
    import irpw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    output irpw_cfg_t            cfg
);

    irpw_cfg_t cfg_reg;
    irpw_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PERIOD_TICKS:  cfg_next.period_ticks  = cfg_data;
                REG_IDLE_PERIODS:  cfg_next.idle_periods  = cfg_data[7:0];
                REG_END_GAP_TICKS: cfg_next.end_gap_ticks = cfg_data;
                REG_MIN_PULSES:    cfg_next.min_pulses    = cfg_data[7:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period_ticks  <= 16'd12500;
            cfg_reg.idle_periods  <= 8'd200;
            cfg_reg.end_gap_ticks <= 16'd30000;
            cfg_reg.min_pulses    <= 8'd10;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: sv/ir_pulse_width_capture_top.sv
// ir_pulse_width_capture_top: IR remote burst learner, top level.
// Depends on irpw_pkg, irpw_cfg and irpw_ram.
// Path: an accepted input word goes to the item register and then to the result
// register; while the result register is stalled, the word waits in the item register.
// Throughput: one input word per cycle while the result register is not stalled; the
// single pass over the item register (state update plus one duration RAM access) sets that figure.
// Reset: asynchronous, active low; clears mode, counters and valid flags.
// The duration RAM itself is not cleared; a fill mark covers it.
`timescale 1ns / 1ps

module ir_pulse_width_capture_top
    import irpw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input word channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  irpw_in_t             in_data,
    // result word channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output irpw_out_t            out_data,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    irpw_cfg_t cfg;

    irpw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // ------------------------------------------------------------------
    // Flow control: item register feeds the result register. The item
    // register empties whenever the result register is free or drained.
    // ------------------------------------------------------------------
    logic      item_valid_reg;
    irpw_in_t  item_reg;
    logic      out_valid_reg;
    irpw_out_t out_data_reg;

    logic advance;
    logic in_accept;
    logic step_en;

    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = item_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign step_en   = item_valid_reg && advance;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Learner state
    // ------------------------------------------------------------------
    mode_t             mode_reg,          mode_next;
    logic              line_high_reg,     line_high_next;
    logic [ADDR_W-1:0] pulse_index_reg,   pulse_index_next;
    logic [DUR_W-1:0]  cur_dur_reg,       cur_dur_next;
    logic [15:0]       wait_ticks_reg,    wait_ticks_next;
    logic [7:0]        wait_periods_reg,  wait_periods_next;
    logic [3:0]        saved_channel_reg, saved_channel_next;
    // Entries [0, fill) were written since the last clear; others read empty.
    logic [FILL_W-1:0] fill_reg,          fill_next;

    // Duration RAM. Read is launched at accept so data lines up with the
    // item register; a write in that same edge to the same entry is caught
    // by the bypass register.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DUR_W-1:0]  ram_wdata;
    logic [DUR_W-1:0]  ram_rdata;
    logic              bypass_hit_reg;
    logic [DUR_W-1:0]  bypass_data_reg;

    irpw_ram #(
        .WIDTH (DUR_W),
        .DEPTH (MAX_PULSES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_accept),
        .raddr (ADDR_W'(in_data.read_index)),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Next-state logic for one item
    // ------------------------------------------------------------------
    logic              rep;          // capture report produced
    status_t           rep_status;
    logic [ADDR_W-1:0] rep_count;
    logic              chk_en;       // store current duration and test gap
    logic [ADDR_W-1:0] chk_idx;
    logic [DUR_W-1:0]  chk_dur;
    logic [15:0]       wt_inc;
    logic [8:0]        wp_inc;
    logic [ADDR_W-1:0] pi_inc;
    logic              lvl_change;

    always_comb
    begin
        mode_next          = mode_reg;
        line_high_next     = line_high_reg;
        pulse_index_next   = pulse_index_reg;
        cur_dur_next       = cur_dur_reg;
        wait_ticks_next    = wait_ticks_reg;
        wait_periods_next  = wait_periods_reg;
        saved_channel_next = saved_channel_reg;
        fill_next          = fill_reg;
        rep                = 1'b0;
        rep_status         = ST_OK;
        rep_count          = '0;
        chk_en             = 1'b0;
        chk_idx            = pulse_index_reg;
        chk_dur            = cur_dur_reg;
        ram_we             = 1'b0;
        ram_waddr          = pulse_index_reg;
        ram_wdata          = cur_dur_reg;
        wt_inc             = wait_ticks_reg + 16'd1;
        wp_inc             = {1'b0, wait_periods_reg} + 9'd1;
        lvl_change         = item_reg.receiver_level != line_high_reg;
        pi_inc             = lvl_change ? pulse_index_reg + ADDR_W'(1) : pulse_index_reg;

        if (item_reg.op == OP_START)
        begin
            saved_channel_next = item_reg.channel;
            mode_next          = MODE_WAIT;
            line_high_next     = 1'b0;
            pulse_index_next   = '0;
            cur_dur_next       = '0;
            wait_ticks_next    = '0;
            wait_periods_next  = '0;
            fill_next          = '0;
        end
        else if (item_reg.op == OP_TICK && mode_reg == MODE_WAIT)
        begin
            wait_ticks_next = wt_inc;
            if (wt_inc >= cfg.period_ticks)
            begin
                wait_ticks_next   = '0;
                wait_periods_next = wp_inc[7:0];
            end
            if (wt_inc >= cfg.period_ticks && wp_inc > {1'b0, cfg.idle_periods})
            begin
                rep        = 1'b1;
                rep_status = ST_TIMEOUT;
            end
            else if (!item_reg.receiver_level)
            begin
                // first carrier sample: entry 0 starts at zero
                mode_next        = MODE_CAPTURE;
                line_high_next   = 1'b0;
                pulse_index_next = '0;
                cur_dur_next     = '0;
                chk_en           = 1'b1;
                chk_idx          = '0;
                chk_dur          = '0;
            end
        end
        else if (item_reg.op == OP_TICK && mode_reg == MODE_CAPTURE)
        begin
            line_high_next = item_reg.receiver_level;
            if (int'(pi_inc) >= MAX_PULSES - 1)
            begin
                // pulse overflow: whole store reads empty again
                fill_next        = '0;
                pulse_index_next = '0;
                cur_dur_next     = '0;
                rep              = 1'b1;
                rep_status       = ST_ERROR;
            end
            else
            begin
                pulse_index_next = pi_inc;
                chk_dur          = lvl_change ? '0 : cur_dur_reg;
                if (chk_dur != EMPTY_ENTRY)
                begin
                    chk_dur = chk_dur + DUR_W'(1);
                end
                cur_dur_next = chk_dur;
                chk_en       = 1'b1;
                chk_idx      = pi_inc;
            end
        end

        if (chk_en)
        begin
            ram_we    = step_en;
            ram_waddr = chk_idx;
            ram_wdata = chk_dur;
            fill_next = FILL_W'(chk_idx) + FILL_W'(1);
            if (chk_dur >= cfg.end_gap_ticks)
            begin
                rep       = 1'b1;
                rep_count = chk_idx;
                if (int'(chk_idx) > int'(cfg.min_pulses))
                begin
                    ram_wdata  = DUR_W'(saved_channel_reg);
                    rep_status = ST_OK;
                end
                else
                begin
                    ram_wdata  = EMPTY_ENTRY;
                    rep_status = ST_ERROR;
                end
            end
        end

        if (rep)
        begin
            mode_next = MODE_OFF;
        end
    end

    // ------------------------------------------------------------------
    // Result word assembly
    // ------------------------------------------------------------------
    logic              res_valid;
    irpw_out_t         res_data;
    logic [DUR_W-1:0]  rd_word;

    always_comb
    begin
        rd_word   = bypass_hit_reg ? bypass_data_reg : ram_rdata;
        res_valid = 1'b0;
        res_data  = '0;
        if (item_reg.op == OP_READ)
        begin
            res_valid       = 1'b1;
            res_data.kind   = KIND_READ;
            res_data.status = ST_OK;
            if (int'(item_reg.read_index) < MAX_PULSES
                && FILL_W'(item_reg.read_index) < fill_reg)
            begin
                res_data.read_value = rd_word;
            end
            else
            begin
                res_data.read_value = EMPTY_ENTRY;
            end
        end
        else if (rep)
        begin
            res_valid            = 1'b1;
            res_data.kind        = KIND_REPORT;
            res_data.status      = rep_status;
            res_data.pulse_count = 8'(rep_count);
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
            bypass_hit_reg    <= 1'b0;
            mode_reg          <= MODE_OFF;
            line_high_reg     <= 1'b0;
            pulse_index_reg   <= '0;
            cur_dur_reg       <= '0;
            wait_ticks_reg    <= '0;
            wait_periods_reg  <= '0;
            saved_channel_reg <= '0;
            fill_reg          <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                item_valid_reg <= 1'b1;
                bypass_hit_reg <= ram_we && (ram_waddr == ADDR_W'(in_data.read_index));
            end
            else if (step_en)
            begin
                item_valid_reg <= 1'b0;
            end

            if (step_en)
            begin
                out_valid_reg     <= res_valid;
                mode_reg          <= mode_next;
                line_high_reg     <= line_high_next;
                pulse_index_reg   <= pulse_index_next;
                cur_dur_reg       <= cur_dur_next;
                wait_ticks_reg    <= wait_ticks_next;
                wait_periods_reg  <= wait_periods_next;
                saved_channel_reg <= saved_channel_next;
                fill_reg          <= fill_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg        <= in_data;
            bypass_data_reg <= ram_wdata;
        end
        if (step_en)
        begin
            out_data_reg <= res_data;
        end
    end

endmodule
